/* rtl/ep2cal_pkg.sv */
package ep2cal_pkg;

  // field widths
  localparam int ES_W    = 32;
  localparam int OFF_W   = 11;
  localparam int ACC_W   = 33;
  localparam int ADJ_W   = 35;
  localparam int DAYS_W  = 16;
  localparam int YEAR_W  = 12;

  // microprogram layout
  localparam int UCODE_LEN = 34;
  localparam int PC_W      = 6;

  localparam logic [PC_W-1:0] PC_LOAD      = 6'd0;
  localparam logic [PC_W-1:0] PC_DAY_LAST  = 6'd16;
  localparam logic [PC_W-1:0] PC_HOUR_LAST = 6'd21;
  localparam logic [PC_W-1:0] PC_MIN_LAST  = 6'd27;
  localparam logic [PC_W-1:0] PC_EPOCH2000 = 6'd28;
  localparam logic [PC_W-1:0] PC_CENTURY   = 6'd29;
  localparam logic [PC_W-1:0] PC_QUAD      = 6'd30;
  localparam logic [PC_W-1:0] PC_YEAR      = 6'd31;
  localparam logic [PC_W-1:0] PC_MONTH     = 6'd32;
  localparam logic [PC_W-1:0] PC_FINISH    = 6'd33;

  // calendar constants
  localparam logic [ACC_W-1:0]  SECS_DAY       = 33'd86400;
  localparam logic [ACC_W-1:0]  SECS_HOUR      = 33'd3600;
  localparam logic [ACC_W-1:0]  SECS_MIN       = 33'd60;
  localparam logic [DAYS_W-1:0] DAYS_TO_2000   = 16'd10957;
  localparam logic [DAYS_W-1:0] DAYS_CENTURY   = 16'd36525;
  localparam logic [DAYS_W-1:0] DAYS_QUAD      = 16'd1461;
  localparam logic [DAYS_W-1:0] DAYS_QUAD_2100 = 16'd1460;
  localparam logic [DAYS_W-1:0] DAYS_YEAR      = 16'd365;
  localparam logic [DAYS_W-1:0] DAYS_LYEAR     = 16'd366;
  localparam logic [YEAR_W-1:0] YEAR_EPOCH     = 12'd1970;
  localparam logic [YEAR_W-1:0] YEAR_2000      = 12'd2000;
  localparam logic [YEAR_W-1:0] YEAR_2100      = 12'd2100;
  localparam logic [3:0]        MONTH_JAN      = 4'd1;
  localparam logic [3:0]        MONTH_FEB      = 4'd2;
  localparam logic [3:0]        MONTH_APR      = 4'd4;
  localparam logic [3:0]        MONTH_JUN      = 4'd6;
  localparam logic [3:0]        MONTH_SEP      = 4'd9;
  localparam logic [3:0]        MONTH_NOV      = 4'd11;

  // micro-operations
  typedef enum logic [3:0] {
    OP_LOAD   = 4'b0001,
    OP_DIVBIT = 4'b0010,
    OP_STEP   = 4'b0100,
    OP_FINISH = 4'b1000
  } op_t;

  // where a finished quotient goes
  typedef enum logic [1:0] {
    DST_NONE = 2'd0,
    DST_DAYS = 2'd1,
    DST_HOUR = 2'd2,
    DST_MIN  = 2'd3
  } dst_t;

  // calendar update on a successful subtract
  typedef enum logic [2:0] {
    INC_NONE    = 3'd0,
    INC_SET2000 = 3'd1,
    INC_ADD100  = 3'd2,
    INC_ADD4    = 3'd3,
    INC_ADD1    = 3'd4,
    INC_MONTH   = 3'd5
  } inc_t;

  // subtrahend source for day steps
  typedef enum logic [1:0] {
    LEN_ROM   = 2'd0,
    LEN_YEAR  = 2'd1,
    LEN_MONTH = 2'd2,
    LEN_QUAD  = 2'd3
  } len_t;

  typedef struct packed {
    op_t              op;
    dst_t             dst;
    inc_t             inc;
    len_t             len;
    logic             loop;
    logic [PC_W-1:0]  target;
    logic [ACC_W-1:0] kval;
  } ucw_t;

  typedef struct packed {
    logic accept;
    logic run;
    ucw_t w;
  } ctl_t;

  typedef struct packed {
    logic ge;
  } stat_t;

  // microprogram store
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '{op: OP_FINISH, dst: DST_NONE, inc: INC_NONE, len: LEN_ROM,
          loop: 1'b0, target: '0, kval: '0};
    if (pc == PC_LOAD) begin
      w.op = OP_LOAD;
    end else if (pc <= PC_DAY_LAST) begin
      w.op   = OP_DIVBIT;
      w.kval = SECS_DAY << (PC_DAY_LAST - pc);
      if (pc == PC_DAY_LAST) w.dst = DST_DAYS;
    end else if (pc <= PC_HOUR_LAST) begin
      w.op   = OP_DIVBIT;
      w.kval = SECS_HOUR << (PC_HOUR_LAST - pc);
      if (pc == PC_HOUR_LAST) w.dst = DST_HOUR;
    end else if (pc <= PC_MIN_LAST) begin
      w.op   = OP_DIVBIT;
      w.kval = SECS_MIN << (PC_MIN_LAST - pc);
      if (pc == PC_MIN_LAST) w.dst = DST_MIN;
    end else if (pc == PC_EPOCH2000) begin
      w.op   = OP_STEP;
      w.inc  = INC_SET2000;
      w.kval = ACC_W'(DAYS_TO_2000);
    end else if (pc == PC_CENTURY) begin
      w.op   = OP_STEP;
      w.inc  = INC_ADD100;
      w.kval = ACC_W'(DAYS_CENTURY);
    end else if (pc == PC_QUAD) begin
      w.op     = OP_STEP;
      w.inc    = INC_ADD4;
      w.len    = LEN_QUAD;
      w.kval   = ACC_W'(DAYS_QUAD);
      w.loop   = 1'b1;
      w.target = PC_QUAD;
    end else if (pc == PC_YEAR) begin
      w.op     = OP_STEP;
      w.inc    = INC_ADD1;
      w.len    = LEN_YEAR;
      w.loop   = 1'b1;
      w.target = PC_YEAR;
    end else if (pc == PC_MONTH) begin
      w.op     = OP_STEP;
      w.inc    = INC_MONTH;
      w.len    = LEN_MONTH;
      w.loop   = 1'b1;
      w.target = PC_MONTH;
    end
    return w;
  endfunction

  // days in a month
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    d = 5'd31;
    case (m) inside
      MONTH_FEB: d = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

/* rtl/ep2cal_seq.sv */
module ep2cal_seq
  import ep2cal_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t st,
  output logic  busy,
  output ctl_t  ctl
);

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  ucw_t            w;
  logic            accept;

  assign accept = start && !busy_r;
  assign w      = ucode(pc_r);

  // step counter with conditional jump
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (accept) begin
      busy_nxt = 1'b1;
      pc_nxt   = PC_LOAD;
    end else if (busy_r) begin
      if (w.op == OP_FINISH) begin
        busy_nxt = 1'b0;
      end else if (w.loop && st.ge) begin
        pc_nxt = w.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign busy       = busy_r;
  assign ctl.accept = accept;
  assign ctl.run    = busy_r;
  assign ctl.w      = w;

endmodule

/* rtl/ep2cal_datapath.sv */
module ep2cal_datapath
  import ep2cal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_t                  ctl,
  output stat_t                 st,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic signed [OFF_W-1:0] cfg_zone_offset_minutes,
  input  logic [ES_W-1:0]       in_epoch_seconds,
  input  logic                  in_leap_active,
  input  logic [9:0]            in_milli_part,
  input  logic [9:0]            in_micro_part,
  input  logic [1:0]            in_sync_quality,
  output logic                  out_valid,
  output logic [YEAR_W-1:0]     out_year_out,
  output logic [3:0]            out_month_out,
  output logic [4:0]            out_day_out,
  output logic [4:0]            out_hour_out,
  output logic [5:0]            out_minute_out,
  output logic [5:0]            out_second_out,
  output logic [9:0]            out_milli_out,
  output logic [9:0]            out_micro_out,
  output logic [1:0]            out_quality_out,
  output logic                  out_clamped
);

  logic signed [OFF_W-1:0] off_r;
  logic [ES_W-1:0]         es_r;
  logic                    leap_r;
  logic [9:0]              milli_r, micro_r;
  logic [1:0]              qual_r;
  logic [ACC_W-1:0]        acc_r;
  logic [DAYS_W-1:0]       q_r, days_r;
  logic [4:0]              hour_r;
  logic [5:0]              min_r;
  logic [YEAR_W-1:0]       year_r;
  logic [3:0]              month_r;
  logic                    clamp_r;
  logic                    out_valid_r;

  logic signed [ADJ_W-1:0] offx, adj;
  logic                    ge_div, ge_step, leap_year;
  logic [DAYS_W-1:0]       len;
  logic [DAYS_W-1:0]       q_shift;

  // zone offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      off_r <= cfg_zone_offset_minutes;
    end
  end

  // input capture on transfer
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      es_r    <= in_epoch_seconds;
      leap_r  <= in_leap_active;
      milli_r <= in_milli_part;
      micro_r <= in_micro_part;
      qual_r  <= in_sync_quality;
    end
  end

  // local seconds: es + 60 * offset - leap, offset times 60 as shift and subtract
  assign offx = ADJ_W'(off_r);
  assign adj  = signed'(ADJ_W'(es_r)) + (offx <<< 6) - (offx <<< 2)
                - signed'(ADJ_W'(leap_r));

  // compare units
  assign leap_year = (year_r[1:0] == 2'b00) && (year_r != YEAR_2100);
  always_comb begin
    len = ctl.w.kval[DAYS_W-1:0];
    case (ctl.w.len)
      LEN_YEAR:  len = leap_year ? DAYS_LYEAR : DAYS_YEAR;
      LEN_MONTH: len = DAYS_W'(month_days(month_r, leap_year));
      // the 4-year block from 2100 has no leap day
      LEN_QUAD:  len = (year_r == YEAR_2100) ? DAYS_QUAD_2100 : DAYS_QUAD;
      default:   len = ctl.w.kval[DAYS_W-1:0];
    endcase
  end
  assign ge_div  = acc_r >= ctl.w.kval;
  assign ge_step = days_r >= len;
  assign st.ge   = (ctl.w.op == OP_DIVBIT) ? ge_div : ge_step;
  assign q_shift = {q_r[DAYS_W-2:0], ge_div};

  // datapath registers driven by the control word
  always_ff @(posedge clk) begin
    if (ctl.run) begin
      unique case (ctl.w.op)
        OP_LOAD: begin
          acc_r   <= adj[ADJ_W-1] ? '0 : adj[ACC_W-1:0];
          clamp_r <= adj[ADJ_W-1];
          q_r     <= '0;
          year_r  <= YEAR_EPOCH;
          month_r <= MONTH_JAN;
        end
        OP_DIVBIT: begin
          if (ge_div) acc_r <= acc_r - ctl.w.kval;
          // quotient restarts once a field is complete
          q_r <= (ctl.w.dst == DST_NONE) ? q_shift : '0;
          case (ctl.w.dst)
            DST_DAYS: days_r <= q_shift;
            DST_HOUR: hour_r <= q_shift[4:0];
            DST_MIN:  min_r  <= q_shift[5:0];
            default: ;
          endcase
        end
        OP_STEP: begin
          if (ge_step) begin
            days_r <= days_r - len;
            case (ctl.w.inc)
              INC_SET2000: year_r  <= YEAR_2000;
              INC_ADD100:  year_r  <= year_r + 12'd100;
              INC_ADD4:    year_r  <= year_r + 12'd4;
              INC_ADD1:    year_r  <= year_r + 12'd1;
              INC_MONTH:   month_r <= month_r + 4'd1;
              default: ;
            endcase
          end
        end
        OP_FINISH: ;
        default: ;
      endcase
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.run && (ctl.w.op == OP_FINISH);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_year_out    = year_r;
  assign out_month_out   = month_r;
  assign out_day_out     = days_r[4:0] + 5'd1;
  assign out_hour_out    = hour_r;
  assign out_minute_out  = min_r;
  assign out_second_out  = acc_r[5:0] + 6'(leap_r && !clamp_r);
  assign out_milli_out   = milli_r;
  assign out_micro_out   = micro_r;
  assign out_quality_out = qual_r;
  assign out_clamped     = clamp_r;

endmodule

/* rtl/epoch_seconds_to_calendar.sv */
// Converts a 32-bit UTC second count since 1970 to local calendar date and
// time, using the zone offset in minutes written on the cfg port (write it
// only while busy is low). A conversion starts when start is high and busy is
// low; busy then stays high until the result appears on the out_ ports for one
// cycle with out_valid, which the receiver must take then. A 34-word
// microprogram drives one compare-subtract datapath: 27 restoring division
// steps split seconds into days, hours, minutes and seconds, then day-count
// steps find the year (2000 and 2100 jumps, then looped 4-year and single
// year steps) and the month (looped). The start-to-out_valid time is set
// mostly by the 4-year steps, single years and months walked; busy falls as
// out_valid rises, so the next start can be taken then. With the leap flag
// set the count loses a second and seconds gain one, so a leap second reads
// 60; times before the epoch return 1970-01-01 00:00:00 with clamped set.
module epoch_seconds_to_calendar
  import ep2cal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic signed [OFF_W-1:0] cfg_zone_offset_minutes,
  input  logic                    start,
  output logic                    busy,
  input  logic [ES_W-1:0]         in_epoch_seconds,
  input  logic                    in_leap_active,
  input  logic [9:0]              in_milli_part,
  input  logic [9:0]              in_micro_part,
  input  logic [1:0]              in_sync_quality,
  output logic                    out_valid,
  output logic [YEAR_W-1:0]       out_year_out,
  output logic [3:0]              out_month_out,
  output logic [4:0]              out_day_out,
  output logic [4:0]              out_hour_out,
  output logic [5:0]              out_minute_out,
  output logic [5:0]              out_second_out,
  output logic [9:0]              out_milli_out,
  output logic [9:0]              out_micro_out,
  output logic [1:0]              out_quality_out,
  output logic                    out_clamped
);

  ctl_t  ctl;
  stat_t st;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // step sequencer
  ep2cal_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .busy  (busy),
    .ctl   (ctl)
  );

  // compare-subtract datapath
  ep2cal_datapath u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .ctl                     (ctl),
    .st                      (st),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_zone_offset_minutes (cfg_zone_offset_minutes),
    .in_epoch_seconds        (in_epoch_seconds),
    .in_leap_active          (in_leap_active),
    .in_milli_part           (in_milli_part),
    .in_micro_part           (in_micro_part),
    .in_sync_quality         (in_sync_quality),
    .out_valid               (out_valid),
    .out_year_out            (out_year_out),
    .out_month_out           (out_month_out),
    .out_day_out             (out_day_out),
    .out_hour_out            (out_hour_out),
    .out_minute_out          (out_minute_out),
    .out_second_out          (out_second_out),
    .out_milli_out           (out_milli_out),
    .out_micro_out           (out_micro_out),
    .out_quality_out         (out_quality_out),
    .out_clamped             (out_clamped)
  );

endmodule

/* rtl/ep2cal_checker.sv */
module ep2cal_checker
  import ep2cal_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [3:0]        out_month_out,
  input logic [4:0]        out_day_out,
  input logic [4:0]        out_hour_out,
  input logic [5:0]        out_minute_out,
  input logic [5:0]        out_second_out
);

  // a transfer starts a conversion
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after start transfer");

  // a result ends a conversion
  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe without a finished conversion");

  // one strobe per result
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // calendar fields in range
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_out >= 4'd1 && out_month_out <= 4'd12 &&
                   out_day_out >= 5'd1))
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour_out <= 5'd23 && out_minute_out <= 6'd59 &&
                   out_second_out <= 6'd60))
    else $error("time of day out of range");

endmodule

bind epoch_seconds_to_calendar ep2cal_checker u_ep2cal_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_month_out  (out_month_out),
  .out_day_out    (out_day_out),
  .out_hour_out   (out_hour_out),
  .out_minute_out (out_minute_out),
  .out_second_out (out_second_out)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ep2cal_pkg::*;

  // clock quality levels carried through the block
  localparam logic [1:0] QUAL_LOST = 2'd0;
  localparam logic [1:0] QUAL_MISS = 2'd1;
  localparam logic [1:0] QUAL_POOR = 2'd2;
  localparam logic [1:0] QUAL_GOOD = 2'd3;

  localparam int SECS_PER_DAY   = 86400;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 144;
  localparam int DRAIN_CYCLES   = 80;
  localparam int MAX_GAP        = 75;

  typedef struct {
    logic [ES_W-1:0] es;
    logic            leap;
    logic [9:0]      milli;
    logic [9:0]      micro;
    logic [1:0]      quality;
  } time_item_t;

  typedef struct {
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [9:0]        milli;
    logic [9:0]        micro;
    logic [1:0]        quality;
    logic              clamped;
  } date_t;

  // expected dates and the local zone they are computed for
  class calendar_scoreboard;
    date_t  expected_dates[$];
    longint zone_minutes;
    int     errors;

    function new();
      zone_minutes = 0;
      errors       = 0;
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void set_zone(input logic signed [OFF_W-1:0] v);
      zone_minutes = v;
    endfunction

    function bit is_leap(input int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // seconds since the epoch plus zone, less a leap second, split into a date
    function date_t epoch_to_date(input time_item_t t);
      int     mlen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      longint adj;
      longint days;
      longint rem;
      int     ylen;
      int     len;
      int     yr;
      int     mo;
      int     sec;
      bit     clip;
      date_t  d;
      adj  = longint'(t.es) + zone_minutes * 60 - longint'(t.leap);
      clip = 1'b0;
      if (adj < 0) begin
        adj  = 0;
        clip = 1'b1;
      end
      days = adj / SECS_PER_DAY;
      rem  = adj % SECS_PER_DAY;
      yr   = 1970;
      ylen = is_leap(yr) ? 366 : 365;
      while (days >= ylen) begin
        days -= ylen;
        yr++;
        ylen = is_leap(yr) ? 366 : 365;
      end
      mo = 1;
      for (int m = 0; m < 11; m++) begin
        len = mlen[m];
        if (m == 1 && is_leap(yr)) len = 29;
        if (days < len) break;
        days -= len;
        mo++;
      end
      // leap second shows up as one more second unless clamped
      sec = int'(rem % 60);
      if (t.leap && !clip) sec++;
      d.year    = YEAR_W'(yr);
      d.month   = 4'(mo);
      d.day     = 5'(days + 1);
      d.hour    = 5'(rem / 3600);
      d.minute  = 6'((rem % 3600) / 60);
      d.second  = 6'(sec);
      d.milli   = t.milli;
      d.micro   = t.micro;
      d.quality = t.quality;
      d.clamped = clip;
      return d;
    endfunction

    function void note_time(input time_item_t t);
      expected_dates.push_back(epoch_to_date(t));
    endfunction

    task compare_field(input string field, input int got, input int want);
      if (got != want)
        report($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task check_calendar(input date_t got);
      date_t want;
      if (expected_dates.size() == 0) begin
        report("result with no conversion outstanding");
        return;
      end
      want = expected_dates.pop_front();
      compare_field("year", int'(got.year), int'(want.year));
      compare_field("month", int'(got.month), int'(want.month));
      compare_field("day", int'(got.day), int'(want.day));
      compare_field("hour", int'(got.hour), int'(want.hour));
      compare_field("minute", int'(got.minute), int'(want.minute));
      compare_field("second", int'(got.second), int'(want.second));
      compare_field("milli", int'(got.milli), int'(want.milli));
      compare_field("micro", int'(got.micro), int'(want.micro));
      compare_field("quality", int'(got.quality), int'(want.quality));
      compare_field("clamped", int'(got.clamped), int'(want.clamped));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic signed [OFF_W-1:0] cfg_zone_offset_minutes = '0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [ES_W-1:0]         in_epoch_seconds = '0;
  logic                    in_leap_active = 1'b0;
  logic [9:0]              in_milli_part = '0;
  logic [9:0]              in_micro_part = '0;
  logic [1:0]              in_sync_quality = QUAL_LOST;
  logic                    out_valid;
  logic [YEAR_W-1:0]       out_year_out;
  logic [3:0]              out_month_out;
  logic [4:0]              out_day_out;
  logic [4:0]              out_hour_out;
  logic [5:0]              out_minute_out;
  logic [5:0]              out_second_out;
  logic [9:0]              out_milli_out;
  logic [9:0]              out_micro_out;
  logic [1:0]              out_quality_out;
  logic                    out_clamped;

  calendar_scoreboard sb = new();
  int sender_idle_pct = 0;

  epoch_seconds_to_calendar u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_zone_offset_minutes (cfg_zone_offset_minutes),
    .start                   (start),
    .busy                    (busy),
    .in_epoch_seconds        (in_epoch_seconds),
    .in_leap_active          (in_leap_active),
    .in_milli_part           (in_milli_part),
    .in_micro_part           (in_micro_part),
    .in_sync_quality         (in_sync_quality),
    .out_valid               (out_valid),
    .out_year_out            (out_year_out),
    .out_month_out           (out_month_out),
    .out_day_out             (out_day_out),
    .out_hour_out            (out_hour_out),
    .out_minute_out          (out_minute_out),
    .out_second_out          (out_second_out),
    .out_milli_out           (out_milli_out),
    .out_micro_out           (out_micro_out),
    .out_quality_out         (out_quality_out),
    .out_clamped             (out_clamped)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watch every transfer on the three channels
  always @(posedge clk) begin
    date_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.year    = out_year_out;
        got.month   = out_month_out;
        got.day     = out_day_out;
        got.hour    = out_hour_out;
        got.minute  = out_minute_out;
        got.second  = out_second_out;
        got.milli   = out_milli_out;
        got.micro   = out_micro_out;
        got.quality = out_quality_out;
        got.clamped = out_clamped;
        sb.check_calendar(got);
      end
      if (start && !busy)
        sb.note_time('{in_epoch_seconds, in_leap_active, in_milli_part,
                       in_micro_part, in_sync_quality});
      if (cfg_valid && cfg_ready)
        sb.set_zone(cfg_zone_offset_minutes);
    end
  end

  function automatic time_item_t mk(input logic [ES_W-1:0] es, input logic leap,
                                    input logic [9:0] milli, input logic [9:0] micro,
                                    input logic [1:0] quality);
    time_item_t t;
    t.es      = es;
    t.leap    = leap;
    t.milli   = milli;
    t.micro   = micro;
    t.quality = quality;
    return t;
  endfunction

  // 45 percent uniform, with clusters at midnight, near the epoch and near the top
  function automatic time_item_t random_time();
    time_item_t t;
    int         pick;
    longint     es;
    pick = $urandom_range(99);
    if (pick < 45)
      es = $urandom;
    else if (pick < 65)
      es = longint'($urandom_range(0, 49710)) * SECS_PER_DAY + $urandom_range(0, 4) - 2;
    else if (pick < 80)
      es = $urandom_range(0, 100000);
    else
      es = 64'hFFFF_FFFF - $urandom_range(0, 100000);
    t.es      = es[ES_W-1:0];
    t.leap    = ($urandom_range(3) == 0);
    t.milli   = 10'($urandom_range(0, 999));
    t.micro   = 10'($urandom_range(0, 999));
    t.quality = 2'($urandom_range(0, 3));
    return t;
  endfunction

  // hold start with the item until the block takes it
  task automatic send_time(input time_item_t t);
    start            <= 1'b1;
    in_epoch_seconds <= t.es;
    in_leap_active   <= t.leap;
    in_milli_part    <= t.milli;
    in_micro_part    <= t.micro;
    in_sync_quality  <= t.quality;
    do @(posedge clk); while (busy);
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
  endtask

  // zone write once the block has drained
  task automatic write_zone(input logic signed [OFF_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (busy || sb.pending() != 0) @(posedge clk);
    cfg_valid               <= 1'b1;
    cfg_zone_offset_minutes <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic signed [OFF_W-1:0] zone;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset zone, epoch edges, leap flag, century and leap days
    send_time(mk(32'd0, 1'b0, 10'd0, 10'd0, QUAL_LOST));
    send_time(mk(32'd0, 1'b1, 10'd999, 10'd999, QUAL_MISS));
    send_time(mk(32'd1, 1'b1, 10'd24, 10'd24, QUAL_POOR));
    send_time(mk(32'hFFFF_FFFF, 1'b0, 10'd999, 10'd999, QUAL_GOOD));
    send_time(mk(32'hFFFF_FFFF, 1'b1, 10'd512, 10'd1, QUAL_GOOD));
    send_time(mk(32'd68169600, 1'b0, 10'd5, 10'd7, QUAL_POOR));
    send_time(mk(32'd946684799, 1'b0, 10'd1, 10'd2, QUAL_MISS));
    send_time(mk(32'd946684800, 1'b1, 10'd3, 10'd4, QUAL_GOOD));
    send_time(mk(32'd951782400, 1'b1, 10'd6, 10'd8, QUAL_GOOD));
    send_time(mk(32'd4107542399, 1'b0, 10'd9, 10'd10, QUAL_POOR));
    send_time(mk(32'd4107542400, 1'b0, 10'd11, 10'd12, QUAL_LOST));
    send_time(mk(32'd1000, 1'b1, 10'd13, 10'd14, QUAL_MISS));

    // lowest intended zone: clamping around the epoch
    write_zone(-11'sd720);
    send_time(mk(32'd0, 1'b0, 10'd100, 10'd200, QUAL_GOOD));
    send_time(mk(32'd43199, 1'b0, 10'd101, 10'd201, QUAL_POOR));
    send_time(mk(32'd43200, 1'b0, 10'd102, 10'd202, QUAL_MISS));
    send_time(mk(32'd43200, 1'b1, 10'd103, 10'd203, QUAL_LOST));
    send_time(mk(32'd43201, 1'b1, 10'd104, 10'd204, QUAL_GOOD));

    // highest intended zone and the raw 11-bit extremes
    write_zone(11'sd840);
    send_time(mk(32'hFFFF_FFFF, 1'b0, 10'd999, 10'd0, QUAL_GOOD));
    send_time(mk(32'hFFFF_FFFF, 1'b1, 10'd0, 10'd999, QUAL_LOST));
    write_zone(-11'sd1024);
    send_time(mk(32'd61439, 1'b0, 10'd7, 10'd7, QUAL_POOR));
    send_time(mk(32'd61440, 1'b0, 10'd8, 10'd8, QUAL_MISS));
    write_zone(11'sd1023);
    send_time(mk(32'hFFFF_FFFF, 1'b0, 10'd9, 10'd9, QUAL_GOOD));
    send_time(mk(32'hFFFF_FFFF, 1'b1, 10'd10, 10'd10, QUAL_GOOD));

    // random phases, each with its own zone and sender idling
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: zone = '0;
        1: zone = -11'sd720;
        2: zone = 11'sd840;
        3: zone = 11'sd330;
        4: zone = -11'sd1024;
        5: zone = 11'sd1023;
        6: zone = 11'($urandom_range(0, 2047));
        default: zone = $signed(11'($urandom_range(0, 1560))) - 11'sd720;
      endcase
      write_zone(zone);
      sender_idle_pct = (phase < 3) ? 19 : (phase < 6) ? 54 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sender_gap();
        send_time(random_time());
      end
    end

    // drain and give the verdict
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d conversions never returned", sb.pending()));
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
